// ===== hdl/line_editor_with_echo_defines.svh =====
// ----------------------------------------------------------------------------
// Line editor assertion macros
// Assertion helpers shared by the RTL files of the line editor.
// ----------------------------------------------------------------------------
`ifndef LINE_EDITOR_WITH_ECHO_DEFINES_SVH
`define LINE_EDITOR_WITH_ECHO_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LEWE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line editor check failed");

// Next-cycle implication, checked out of reset.
`define LEWE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line editor check failed");

`endif

// ===== hdl/lewe_pkg.sv =====
// ----------------------------------------------------------------------------
// Line editor package
// Character codes, result targets and the cell control bundle.
// ----------------------------------------------------------------------------
package lewe_pkg;

    localparam int LINE_DEPTH_DEF = 32;
    localparam int BYTE_W         = 8;
    localparam int TGT_W          = 2;
    localparam int LEN_W          = 6;

    localparam logic [BYTE_W-1:0] CH_BEL = 8'd7;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'd0;

    localparam logic [TGT_W-1:0] TGT_TX    = 2'd0;
    localparam logic [TGT_W-1:0] TGT_CHAR  = 2'd1;
    localparam logic [TGT_W-1:0] TGT_EMPTY = 2'd2;

    typedef struct packed {
        logic              shift;
        logic              wr;
        logic [BYTE_W-1:0] wr_data;
    } t_cell_ctl;

endpackage

// ===== hdl/lewe_cell.sv =====
// ----------------------------------------------------------------------------
// Line store cell
// Holds one character; loads it when the fill count points here, or takes
// the neighbor's character while the line drains toward cell zero.
// ----------------------------------------------------------------------------
module lewe_cell #(
    parameter int CNT_W = 6,
    parameter int IDX   = 0
) (
    input  logic                          i_clk,
    input  lewe_pkg::t_cell_ctl           i_ctl,
    input  logic [CNT_W-1:0]              i_fill,
    input  logic [lewe_pkg::BYTE_W-1:0]   i_next_data,
    output logic [lewe_pkg::BYTE_W-1:0]   o_data
);

    logic [lewe_pkg::BYTE_W-1:0] r_data;
    logic [lewe_pkg::BYTE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_next_data;
        end else if (i_ctl.wr && (i_fill == CNT_W'(IDX))) begin
            n_data = i_ctl.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hdl/line_editor_with_echo.sv =====
// ----------------------------------------------------------------------------
// Line editor with echo
// Edits a bounded line from received bytes, echoes to the terminal and
// hands out the finished line one character at a time.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one received byte
//   per request. Results leave on the res channel (o_res_valid / i_res_ready)
//   as target, data byte, line length and a last flag on the final result of
//   each byte. i_cfg_we / i_cfg_wdata write echo_enable at any edge.
//   A byte is taken only while the sequencer is idle. Acceptance loads the
//   state register and the first result is then registered in the output
//   register; more follow one result per cycle while the receiver takes
//   them. A carriage return drains the cell chain one character per cycle
//   toward cell zero while the receiver takes them. A stalled receiver holds
//   the output register and freezes the sequencer. Reset empties the line,
//   turns echo on and drops any pending result; the store itself is not
//   cleared since only filled cells are ever read.
// ----------------------------------------------------------------------------
`include "line_editor_with_echo_defines.svh"

module line_editor_with_echo #(
    parameter int LINE_DEPTH = lewe_pkg::LINE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_rx_valid,
    output logic                          o_rx_ready,
    input  logic [lewe_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [lewe_pkg::TGT_W-1:0]    o_target,
    output logic [lewe_pkg::BYTE_W-1:0]   o_data_byte,
    output logic [lewe_pkg::LEN_W-1:0]    o_line_length,
    output logic                          o_last
);

    localparam int CNT_W = $clog2(LINE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TX    = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                    r_state,   n_state;
    logic [CNT_W-1:0]              r_fill,    n_fill;
    logic                          r_echo;
    logic [1:0]                    r_tx_cnt,  n_tx_cnt;
    logic                          r_flush,   n_flush;
    logic [CNT_W-1:0]              r_left,    n_left;
    logic [CNT_W-1:0]              r_len,     n_len;
    logic [lewe_pkg::BYTE_W-1:0]   r_tx [3];
    logic [lewe_pkg::BYTE_W-1:0]   n_tx [3];

    logic                          r_res_valid;
    logic [lewe_pkg::TGT_W-1:0]    r_tgt,  n_tgt;
    logic [lewe_pkg::BYTE_W-1:0]   r_data, n_data;
    logic [lewe_pkg::LEN_W-1:0]    r_olen, n_olen;
    logic                          r_last, n_last;

    logic                          rx_accept;
    logic                          slot_free;
    logic                          emit;
    logic                          is_cr, is_lf, is_bs, full;
    lewe_pkg::t_cell_ctl           cell_ctl;
    logic [lewe_pkg::BYTE_W-1:0]   w_cell [LINE_DEPTH+1];

    assign o_rx_ready = (r_state == ST_IDLE);
    assign rx_accept  = i_rx_valid && o_rx_ready;
    assign slot_free  = !r_res_valid || i_res_ready;
    assign emit       = slot_free && (r_state != ST_IDLE);

    assign is_cr = (i_rx_byte == lewe_pkg::CH_CR);
    assign is_lf = (i_rx_byte == lewe_pkg::CH_LF);
    assign is_bs = (i_rx_byte == lewe_pkg::CH_BS);
    assign full  = (r_fill == CNT_W'(LINE_DEPTH));

    // Row of storage cells; the one past the end feeds zero into the chain.
    assign w_cell[LINE_DEPTH] = lewe_pkg::CH_NUL;

    for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
        lewe_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_fill      (r_fill),
            .i_next_data (w_cell[g+1]),
            .o_data      (w_cell[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_tx_cnt = r_tx_cnt;
        n_flush  = r_flush;
        n_left   = r_left;
        n_len    = r_len;
        n_tx     = r_tx;
        n_tgt    = r_tgt;
        n_data   = r_data;
        n_olen   = r_olen;
        n_last   = r_last;
        cell_ctl = '{shift: 1'b0, wr: 1'b0, wr_data: i_rx_byte};

        if (rx_accept) begin
            priority if (is_cr) begin
                n_len   = r_fill;
                n_left  = r_fill;
                n_fill  = '0;
                n_flush = 1'b1;
                if (r_echo) begin
                    n_tx     = '{lewe_pkg::CH_CR, lewe_pkg::CH_LF, lewe_pkg::CH_NUL};
                    n_tx_cnt = 2'd2;
                    n_state  = ST_TX;
                end else begin
                    n_state = ST_FLUSH;
                end
            end else if (is_lf) begin
                n_flush = 1'b0;
                if (r_echo) begin
                    n_tx     = '{lewe_pkg::CH_CR, lewe_pkg::CH_LF, lewe_pkg::CH_NUL};
                    n_tx_cnt = 2'd2;
                    n_state  = ST_TX;
                end
            end else if (is_bs) begin
                n_flush = 1'b0;
                n_state = ST_TX;
                if (r_fill == '0) begin
                    n_tx     = '{lewe_pkg::CH_BEL, lewe_pkg::CH_NUL, lewe_pkg::CH_NUL};
                    n_tx_cnt = 2'd1;
                end else begin
                    n_tx     = '{lewe_pkg::CH_BS, lewe_pkg::CH_SP, lewe_pkg::CH_BS};
                    n_tx_cnt = 2'd3;
                    n_fill   = r_fill - 1'b1;
                end
            end else begin
                n_flush = 1'b0;
                if (full) begin
                    n_tx     = '{lewe_pkg::CH_BEL, lewe_pkg::CH_NUL, lewe_pkg::CH_NUL};
                    n_tx_cnt = 2'd1;
                    n_state  = ST_TX;
                end else begin
                    cell_ctl.wr = 1'b1;
                    n_fill      = r_fill + 1'b1;
                    if (r_echo) begin
                        n_tx     = '{i_rx_byte, lewe_pkg::CH_NUL, lewe_pkg::CH_NUL};
                        n_tx_cnt = 2'd1;
                        n_state  = ST_TX;
                    end
                end
            end
        end

        if (emit) begin
            unique case (r_state)
                ST_TX: begin
                    n_tgt    = lewe_pkg::TGT_TX;
                    n_data   = r_tx[0];
                    n_olen   = '0;
                    n_last   = (r_tx_cnt == 2'd1) && !r_flush;
                    n_tx[0]  = r_tx[1];
                    n_tx[1]  = r_tx[2];
                    n_tx_cnt = r_tx_cnt - 1'b1;
                    if (r_tx_cnt == 2'd1) begin
                        n_state = r_flush ? ST_FLUSH : ST_IDLE;
                    end
                end
                ST_FLUSH: begin
                    if (r_len == '0) begin
                        n_tgt   = lewe_pkg::TGT_EMPTY;
                        n_data  = lewe_pkg::CH_NUL;
                        n_olen  = '0;
                        n_last  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        // Take cell zero and advance the chain by one.
                        n_tgt          = lewe_pkg::TGT_CHAR;
                        n_data         = w_cell[0];
                        n_olen         = lewe_pkg::LEN_W'(r_len);
                        n_last         = (r_left == CNT_W'(1));
                        n_left         = r_left - 1'b1;
                        cell_ctl.shift = 1'b1;
                        if (r_left == CNT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_echo      <= 1'b1;
            r_tx_cnt    <= '0;
            r_flush     <= 1'b0;
            r_left      <= '0;
            r_len       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_tx_cnt <= n_tx_cnt;
            r_flush  <= n_flush;
            r_left   <= n_left;
            r_len    <= n_len;
            if (i_cfg_we) begin
                r_echo <= i_cfg_wdata;
            end
            if (emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tx   <= n_tx;
        r_tgt  <= n_tgt;
        r_data <= n_data;
        r_olen <= n_olen;
        r_last <= n_last;
    end

    assign o_res_valid   = r_res_valid;
    assign o_target      = r_tgt;
    assign o_data_byte   = r_data;
    assign o_line_length = r_olen;
    assign o_last        = r_last;

    `LEWE_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CNT_W'(LINE_DEPTH))
    `LEWE_ASSERT_NEXT(a_cr_clears, rx_accept && is_cr, r_fill == '0)
    `LEWE_ASSERT_NEXT(a_bs_drops, rx_accept && is_bs && (r_fill != '0),
        r_fill == $past(r_fill) - 1'b1)
    `LEWE_ASSERT_NEXT(a_flush_last,
        emit && (r_state == ST_FLUSH) && (r_len != '0) && (r_left == CNT_W'(1)),
        o_res_valid && o_last && (o_target == lewe_pkg::TGT_CHAR))

endmodule
